// ===== design/hpw_pkg.sv =====
// Package for the heading PID block: field widths, register indexes,
// configuration struct and reset values. No dependencies.
`default_nettype none

package hpw_pkg;

  // Field and datapath widths
  localparam int AngW    = 14;  // input headings
  localparam int ErrW    = 13;  // wrapped error, [-2880,2880]
  localparam int DerW    = 14;  // error difference, [-5760,5760]
  localparam int AccW    = 16;  // integral accumulator
  localparam int GainW   = 16;  // unsigned Q8.8 gains
  localparam int LimW    = 15;  // integral and drive clamps
  localparam int BandW   = 12;  // separation band
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 16;  // widest register
  localparam int ProdW   = 33;  // widest product (17 x 16 signed)
  localparam int SumW    = 34;  // sum of three products
  localparam int DrvW    = 16;  // drive output
  localparam int FracW   = 8;   // Q8.8 fraction bits

  // Angle constants in 1/16 degree
  localparam int HalfTurn = 2880;
  localparam int FullTurn = 5760;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegPropGain  = 3'd0,
    RegIntegGain = 3'd1,
    RegDerivGain = 3'd2,
    RegIntegLim  = 3'd3,
    RegDriveLim  = 3'd4,
    RegSepBand   = 3'd5
  } hpw_reg_t;

  // Current configuration, shared by the error, product and output stages
  typedef struct packed {
    logic [GainW-1:0] prop_gain;
    logic [GainW-1:0] integ_gain;
    logic [GainW-1:0] deriv_gain;
    logic [LimW-1:0]  integ_limit;
    logic [LimW-1:0]  drive_limit;
    logic [BandW-1:0] separation_band;
  } hpw_cfg_t;

  // Reset values
  localparam logic [GainW-1:0] PropGainRst  = 16'd3072;
  localparam logic [GainW-1:0] IntegGainRst = 16'd512;
  localparam logic [GainW-1:0] DerivGainRst = 16'd512;
  localparam logic [LimW-1:0]  IntegLimRst  = 15'd560;
  localparam logic [LimW-1:0]  DriveLimRst  = 15'd5600;
  localparam logic [BandW-1:0] SepBandRst   = 12'd480;

endpackage

`default_nettype wire

// ===== design/hpw_cfg.sv =====
// Configuration register file for the heading PID block.
// Depends on hpw_pkg.
`default_nettype none

module hpw_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [hpw_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [hpw_pkg::CfgW-1:0]    cfg_data,
  output hpw_pkg::hpw_cfg_t               cfg
);
  import hpw_pkg::*;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain       <= PropGainRst;
      cfg.integ_gain      <= IntegGainRst;
      cfg.deriv_gain      <= DerivGainRst;
      cfg.integ_limit     <= IntegLimRst;
      cfg.drive_limit     <= DriveLimRst;
      cfg.separation_band <= SepBandRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegPropGain:  cfg.prop_gain       <= cfg_data;
        RegIntegGain: cfg.integ_gain      <= cfg_data;
        RegDerivGain: cfg.deriv_gain      <= cfg_data;
        RegIntegLim:  cfg.integ_limit     <= cfg_data[LimW-1:0];
        RegDriveLim:  cfg.drive_limit     <= cfg_data[LimW-1:0];
        RegSepBand:   cfg.separation_band <= cfg_data[BandW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/hpw_error.sv =====
// Error stage: heading wrap, error wrap, integral update with separation,
// and derivative. Holds the loop state (accumulator, last error).
// Depends on hpw_pkg.
`default_nettype none

module hpw_error (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           load,
  input  wire logic signed [hpw_pkg::AngW-1:0] target_q,
  input  wire logic signed [hpw_pkg::AngW-1:0] meas_q,
  input  wire hpw_pkg::hpw_cfg_t              cfg,
  output logic signed [hpw_pkg::ErrW-1:0]     err,
  output logic signed [hpw_pkg::DerW-1:0]     deriv,
  output logic signed [hpw_pkg::AccW-1:0]     accum
);
  import hpw_pkg::*;

  localparam logic signed [AngW:0]   MHalf  = (AngW+1)'(HalfTurn);
  localparam logic signed [AngW:0]   MFull  = (AngW+1)'(FullTurn);
  localparam logic signed [AngW+1:0] EHalf  = (AngW+2)'(HalfTurn);
  localparam logic signed [AngW+1:0] EFull  = (AngW+2)'(FullTurn);
  localparam logic signed [AngW+1:0] EHalf3 = (AngW+2)'(HalfTurn + FullTurn);
  localparam logic signed [AngW+1:0] EFull2 = (AngW+2)'(2 * FullTurn);

  logic signed [AngW:0]   meas_x;
  logic signed [AngW:0]   meas_w;
  logic signed [AngW+1:0] diff;
  logic signed [AngW+1:0] diff_w;
  logic signed [AngW+1:0] mag;
  logic signed [ErrW-1:0] err_next;
  logic signed [DerW-1:0] deriv_next;
  logic signed [AccW:0]   acc_sum;
  logic signed [AccW:0]   lim;
  logic signed [AccW:0]   neg_lim;
  logic signed [AccW-1:0] accum_next;
  logic                   integ_en;

  always_comb begin
    // Measured heading: one turn is enough for any 14-bit value
    meas_x = {meas_q[AngW-1], meas_q};
    if (meas_x > MHalf) begin
      meas_w = meas_x - MFull;
    end else if (meas_x < -MHalf) begin
      meas_w = meas_x + MFull;
    end else begin
      meas_w = meas_x;
    end

    // Error: may need up to two turns
    diff = {{2{target_q[AngW-1]}}, target_q} - {meas_w[AngW], meas_w};
    if (diff > EHalf3) begin
      diff_w = diff - EFull2;
    end else if (diff > EHalf) begin
      diff_w = diff - EFull;
    end else if (diff < -EHalf3) begin
      diff_w = diff + EFull2;
    end else if (diff < -EHalf) begin
      diff_w = diff + EFull;
    end else begin
      diff_w = diff;
    end
    err_next = diff_w[ErrW-1:0];
    mag      = diff_w[AngW+1] ? -diff_w : diff_w;

    // Integral separation and clamp
    integ_en = (|cfg.integ_gain) && (mag[BandW-1:0] < cfg.separation_band);
    acc_sum  = {accum[AccW-1], accum} + {{(AccW+1-ErrW){err_next[ErrW-1]}}, err_next};
    lim      = {2'b00, cfg.integ_limit};
    neg_lim  = -lim;
    if (acc_sum > lim) begin
      accum_next = lim[AccW-1:0];
    end else if (acc_sum < neg_lim) begin
      accum_next = neg_lim[AccW-1:0];
    end else begin
      accum_next = acc_sum[AccW-1:0];
    end

    deriv_next = {err_next[ErrW-1], err_next} - {err[ErrW-1], err};
  end

  // State and stage registers; err doubles as the last error
  always_ff @(posedge clk) begin
    if (rst) begin
      err   <= '0;
      accum <= '0;
    end else if (load) begin
      err <= err_next;
      if (integ_en) begin
        accum <= accum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      deriv <= deriv_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/hpw_mult.sv =====
// Product stage: the three gain products, each registered.
// Depends on hpw_pkg.
`default_nettype none

module hpw_mult (
  input  wire logic                            clk,
  input  wire logic                            load,
  input  wire hpw_pkg::hpw_cfg_t               cfg,
  input  wire logic signed [hpw_pkg::ErrW-1:0] err,
  input  wire logic signed [hpw_pkg::DerW-1:0] deriv,
  input  wire logic signed [hpw_pkg::AccW-1:0] accum,
  output logic signed [hpw_pkg::ProdW-1:0]     p_prod,
  output logic signed [hpw_pkg::ProdW-1:0]     d_prod,
  output logic signed [hpw_pkg::ProdW-1:0]     i_prod
);
  import hpw_pkg::*;

  logic signed [GainW:0]        p_gain;
  logic signed [GainW:0]        d_gain;
  logic signed [GainW:0]        i_gain;
  logic signed [GainW+ErrW:0]   p_full;
  logic signed [GainW+DerW:0]   d_full;
  logic signed [GainW+AccW:0]   i_full;

  // Unsigned gains widened by a zero sign bit
  always_comb begin
    p_gain = {1'b0, cfg.prop_gain};
    d_gain = {1'b0, cfg.deriv_gain};
    i_gain = {1'b0, cfg.integ_gain};
    p_full = p_gain * err;
    d_full = d_gain * deriv;
    i_full = i_gain * accum;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p_prod <= {{(ProdW-GainW-ErrW-1){p_full[GainW+ErrW]}}, p_full};
      d_prod <= {{(ProdW-GainW-DerW-1){d_full[GainW+DerW]}}, d_full};
      i_prod <= i_full;
    end
  end

endmodule

`default_nettype wire

// ===== design/hpw_output.sv =====
// Output stage: sum of products, floor shift out of Q8.8, drive clamp,
// and the output register. Depends on hpw_pkg.
`default_nettype none

module hpw_output (
  input  wire logic                             clk,
  input  wire logic                             load,
  input  wire hpw_pkg::hpw_cfg_t                cfg,
  input  wire logic signed [hpw_pkg::ProdW-1:0] p_prod,
  input  wire logic signed [hpw_pkg::ProdW-1:0] d_prod,
  input  wire logic signed [hpw_pkg::ProdW-1:0] i_prod,
  output logic signed [hpw_pkg::DrvW-1:0]       drive
);
  import hpw_pkg::*;

  localparam int ShW = SumW - FracW;

  logic signed [SumW-1:0] sum;
  logic signed [ShW-1:0]  shifted;
  logic signed [ShW-1:0]  lim;
  logic signed [ShW-1:0]  clamped;

  always_comb begin
    sum = {p_prod[ProdW-1], p_prod} + {d_prod[ProdW-1], d_prod}
        + {i_prod[ProdW-1], i_prod};
    // Dropping the low bits of a two's complement value floors it
    shifted = sum[SumW-1:FracW];
    lim     = {{(ShW-LimW){1'b0}}, cfg.drive_limit};
    if (shifted > lim) begin
      clamped = lim;
    end else if (shifted < -lim) begin
      clamped = -lim;
    end else begin
      clamped = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive <= clamped[DrvW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/heading_pid_with_wrap_unit.sv =====
// Heading PID with angle wrap and integral separation: top level.
// Depends on hpw_pkg, hpw_cfg, hpw_error, hpw_mult, hpw_output.
//
// Usage:
//   Input channel (in_valid/in_ready) carries target_heading and
//   measured_heading, signed 1/16 degree. Output channel
//   (out_valid/out_ready) carries drive, one item per input item, in order.
//   Registers are written through cfg_we/cfg_index/cfg_data while no item
//   is in flight; indexes above 5 are ignored.
// Timing:
//   Four register stages: input, error/state, products, output. An item
//   accepted on the input passes through them in that order to the output.
//   One item per cycle is taken back to back while out_ready stays high;
//   the loop state (accumulator and last error) is updated in the error
//   stage, so consecutive items see each other's state without a gap.
// Stalls:
//   When out_ready is low, the full stages hold; empty stages ahead of a
//   held stage still fill, so up to four items sit in the pipeline before
//   in_ready drops.
// Reset:
//   rst clears all stage valids, the accumulator and the last error, and
//   loads the register reset values.
`default_nettype none

module heading_pid_with_wrap_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [hpw_pkg::AngW-1:0] target_heading,
  input  wire logic signed [hpw_pkg::AngW-1:0] measured_heading,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [hpw_pkg::DrvW-1:0]      drive,
  input  wire logic                            cfg_we,
  input  wire logic [hpw_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [hpw_pkg::CfgW-1:0]        cfg_data
);
  import hpw_pkg::*;

  hpw_cfg_t               cfg;
  logic                   v0;
  logic                   v1;
  logic                   v2;
  logic                   adv0;
  logic                   adv1;
  logic                   adv2;
  logic                   adv3;
  logic signed [AngW-1:0] target_q;
  logic signed [AngW-1:0] meas_q;
  logic signed [ErrW-1:0] err;
  logic signed [DerW-1:0] deriv;
  logic signed [AccW-1:0] accum;
  logic signed [ProdW-1:0] p_prod;
  logic signed [ProdW-1:0] d_prod;
  logic signed [ProdW-1:0] i_prod;

  // A stage may take a new item when empty or when its own item moves on
  always_comb begin
    adv3     = !out_valid || out_ready;
    adv2     = !v2 || adv3;
    adv1     = !v1 || adv2;
    adv0     = !v0 || adv1;
    in_ready = adv0;
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv0) v0 <= in_valid;
      if (adv1) v1 <= v0;
      if (adv2) v2 <= v1;
      if (adv3) out_valid <= v2;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (adv0 && in_valid) begin
      target_q <= target_heading;
      meas_q   <= measured_heading;
    end
  end

  hpw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hpw_error u_error (
    .clk      (clk),
    .rst      (rst),
    .load     (adv1 && v0),
    .target_q (target_q),
    .meas_q   (meas_q),
    .cfg      (cfg),
    .err      (err),
    .deriv    (deriv),
    .accum    (accum)
  );

  hpw_mult u_mult (
    .clk    (clk),
    .load   (adv2 && v1),
    .cfg    (cfg),
    .err    (err),
    .deriv  (deriv),
    .accum  (accum),
    .p_prod (p_prod),
    .d_prod (d_prod),
    .i_prod (i_prod)
  );

  hpw_output u_output (
    .clk    (clk),
    .load   (adv3 && v2),
    .cfg    (cfg),
    .p_prod (p_prod),
    .d_prod (d_prod),
    .i_prod (i_prod),
    .drive  (drive)
  );

  // Wrapped error stays within half a turn
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (err <= ErrW'(HalfTurn)) && (err >= -ErrW'(HalfTurn)))
    else $error("wrapped error out of range");

  // Drive honors the clamp while shown
  a_drive_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed({drive[DrvW-1], drive}) <= $signed({2'b00, cfg.drive_limit}))
              && ($signed({drive[DrvW-1], drive}) >= -$signed({2'b00, cfg.drive_limit})))
    else $error("drive exceeds clamp");

  // A held product stage keeps its item
  a_prod_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !adv2 |=> v2 && $stable(p_prod) && $stable(i_prod))
    else $error("product stage lost an item");

  // Loop state moves only when an item enters the error stage
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(adv1 && v0) |=> $stable(accum) && $stable(err))
    else $error("loop state changed without an item");

endmodule

`default_nettype wire
